// ----- rtl/core/grid_min_height_ground_filter_assert.svh -----
// assertion macros for the grid minimum-height ground filter
// used by the top level only, no other dependencies
`ifndef GRID_MIN_HEIGHT_GROUND_FILTER_ASSERT_SVH
`define GRID_MIN_HEIGHT_GROUND_FILTER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define GMHGF_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled during reset
`define GMHGF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ----- rtl/core/gmhgf_pkg.sv -----
// shared types and constants of the grid minimum-height ground filter
// no dependencies
`timescale 1ns / 1ps

package gmhgf_pkg;

   localparam logic [1:0] OP_CLEAR      = 2'd0;
   localparam logic [1:0] OP_ACCUMULATE = 2'd1;
   localparam logic [1:0] OP_FILTER     = 2'd2;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 15;

   localparam logic [CSR_INDEX_W-1:0] CSR_CELL_SHIFT    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GROUND_MARGIN = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SKY_MARGIN    = 2'd2;

   localparam logic [3:0]  CELL_SHIFT_RESET    = 4'd7;
   localparam logic [14:0] GROUND_MARGIN_RESET = 15'd26;
   localparam logic [14:0] SKY_MARGIN_RESET    = 15'd768;

   localparam logic signed [15:0] CELL_EMPTY = 16'sh7fff;

   typedef struct packed {
      logic [1:0]          operation;
      logic signed [15:0]  pos_x;
      logic signed [15:0]  pos_y;
      logic signed [15:0]  pos_z;
      logic signed [15:0]  shift_x;
      logic signed [15:0]  shift_y;
      logic signed [15:0]  shift_z;
   } req_payload_type;

   typedef struct packed {
      logic signed [15:0]  kept_x;
      logic signed [15:0]  kept_y;
      logic signed [15:0]  kept_z;
   } rsp_payload_type;

   typedef struct packed {
      logic capture;
      logic bin;
      logic mem_read;
      logic update;
      logic sweep;
   } ctrl_cmd_type;

   typedef struct packed {
      logic req_is_clear;
      logic sweep_last;
      logic update_hold;
   } dp_status_type;

endpackage

// ----- rtl/core/gmhgf_ram.sv -----
// generic one-write one-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module gmhgf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/gmhgf_ctrl.sv -----
// controller state machine: sweep, accept, bin, read, update
// depends on gmhgf_pkg
`timescale 1ns / 1ps

module gmhgf_ctrl
   import gmhgf_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   typedef enum logic [4:0] {
      ST_SWEEP  = 5'b00001,
      ST_IDLE   = 5'b00010,
      ST_BIN    = 5'b00100,
      ST_READ   = 5'b01000,
      ST_UPDATE = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_SWEEP: begin
            cmd.sweep = 1'b1;
            if (status.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = status.req_is_clear ? ST_SWEEP : ST_BIN;
            end
         end
         ST_BIN: begin
            cmd.bin  = 1'b1;
            state_in = ST_READ;
         end
         ST_READ: begin
            cmd.mem_read = 1'b1;
            state_in     = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (!status.update_hold) begin
               cmd.update = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_SWEEP;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SWEEP;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

// ----- rtl/core/gmhgf_datapath.sv -----
// datapath: config registers, offset add, binning, cell memory, judge, output register
// depends on gmhgf_pkg and gmhgf_ram
`timescale 1ns / 1ps

module gmhgf_datapath
   import gmhgf_pkg::*;
#(
   parameter int GRID_CELLS = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   input  req_payload_type        req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_payload_type        rsp_payload,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  ctrl_cmd_type           cmd,
   output dp_status_type          status
);

   localparam int DEPTH  = GRID_CELLS * GRID_CELLS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CELL_W = $clog2(GRID_CELLS);
   localparam int HALF   = GRID_CELLS / 2;

   // config registers
   logic [3:0]  cell_shift_ff, cell_shift_in;
   logic [14:0] ground_margin_ff, ground_margin_in;
   logic [14:0] sky_margin_ff, sky_margin_in;

   always_comb begin
      cell_shift_in    = cell_shift_ff;
      ground_margin_in = ground_margin_ff;
      sky_margin_in    = sky_margin_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_CELL_SHIFT:    cell_shift_in    = csr_wdata[3:0];
            CSR_GROUND_MARGIN: ground_margin_in = csr_wdata[14:0];
            CSR_SKY_MARGIN:    sky_margin_in    = csr_wdata[14:0];
            default: begin
            end
         endcase
      end
   end

   // item capture, with offset add for accumulate items
   logic [1:0]          op_ff, op_in;
   rsp_payload_type     kept_ff, kept_in;
   logic signed [16:0]  sum_x_ff, sum_x_in;
   logic signed [16:0]  sum_y_ff, sum_y_in;
   logic signed [15:0]  z_ff, z_in;
   logic signed [16:0]  sum_z;
   logic                is_acc_req;

   assign is_acc_req = (req_payload.operation == OP_ACCUMULATE);
   assign sum_z = {req_payload.pos_z[15], req_payload.pos_z}
                + {req_payload.shift_z[15], req_payload.shift_z};

   always_comb begin
      op_in    = op_ff;
      kept_in  = kept_ff;
      sum_x_in = sum_x_ff;
      sum_y_in = sum_y_ff;
      z_in     = z_ff;
      if (cmd.capture) begin
         op_in          = req_payload.operation;
         kept_in.kept_x = req_payload.pos_x;
         kept_in.kept_y = req_payload.pos_y;
         kept_in.kept_z = req_payload.pos_z;
         sum_x_in = {req_payload.pos_x[15], req_payload.pos_x};
         sum_y_in = {req_payload.pos_y[15], req_payload.pos_y};
         z_in     = req_payload.pos_z;
         if (is_acc_req) begin
            sum_x_in = {req_payload.pos_x[15], req_payload.pos_x}
                     + {req_payload.shift_x[15], req_payload.shift_x};
            sum_y_in = {req_payload.pos_y[15], req_payload.pos_y}
                     + {req_payload.shift_y[15], req_payload.shift_y};
            if (sum_z[16] != sum_z[15]) begin
               z_in = sum_z[16] ? 16'sh8000 : 16'sh7fff;
            end else begin
               z_in = sum_z[15:0];
            end
         end
      end
   end

   // binning
   logic signed [16:0]  bin_x, bin_y, cx_full, cy_full;
   logic [CELL_W-1:0]   cx_ff, cx_in, cy_ff, cy_in;
   logic                in_grid_ff, in_grid_in;

   assign bin_x   = sum_x_ff >>> cell_shift_ff;
   assign bin_y   = sum_y_ff >>> cell_shift_ff;
   assign cx_full = bin_x + $signed(17'(HALF));
   assign cy_full = bin_y + $signed(17'(HALF));

   always_comb begin
      cx_in      = cx_ff;
      cy_in      = cy_ff;
      in_grid_in = in_grid_ff;
      if (cmd.bin) begin
         cx_in      = cx_full[CELL_W-1:0];
         cy_in      = cy_full[CELL_W-1:0];
         in_grid_in = (cx_full >= 17'sd0) && (cx_full < $signed(17'(GRID_CELLS)))
                   && (cy_full >= 17'sd0) && (cy_full < $signed(17'(GRID_CELLS)));
      end
   end

   // cell memory
   logic [ADDR_W-1:0]  cell_addr;
   logic [ADDR_W-1:0]  sweep_cnt_ff, sweep_cnt_in;
   logic               ram_wr_en;
   logic [ADDR_W-1:0]  ram_wr_addr;
   logic [15:0]        ram_wr_data;
   logic [15:0]        ram_rd_data;

   assign cell_addr = ADDR_W'(cx_ff) * ADDR_W'(GRID_CELLS) + ADDR_W'(cy_ff);

   always_comb begin
      sweep_cnt_in = sweep_cnt_ff;
      if (cmd.sweep) begin
         sweep_cnt_in = status.sweep_last ? '0 : sweep_cnt_ff + 1'b1;
      end
   end

   // judge
   logic signed [15:0] cell_min;
   logic signed [17:0] min_ext, z_ext, lo_bound, hi_bound;
   logic               acc_write, emit;

   assign cell_min = $signed(ram_rd_data);
   assign min_ext  = {{2{cell_min[15]}}, cell_min};
   assign z_ext    = {{2{z_ff[15]}}, z_ff};
   assign lo_bound = min_ext + $signed({3'b000, ground_margin_ff});
   assign hi_bound = min_ext + $signed({3'b000, sky_margin_ff});

   assign acc_write = (op_ff == OP_ACCUMULATE) && in_grid_ff && (z_ff < cell_min);
   assign emit      = (op_ff == OP_FILTER) && in_grid_ff
                   && (lo_bound < z_ext) && (z_ext < hi_bound);

   assign ram_wr_en   = cmd.sweep || (cmd.update && acc_write);
   assign ram_wr_addr = cmd.sweep ? sweep_cnt_ff : cell_addr;
   assign ram_wr_data = cmd.sweep ? CELL_EMPTY : z_ff;

   gmhgf_ram #(
      .WIDTH (16),
      .DEPTH (DEPTH)
   ) u_cell_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (cmd.mem_read),
      .rd_addr (cell_addr),
      .rd_data (ram_rd_data)
   );

   // output register
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.update && emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = kept_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_shift_ff    <= CELL_SHIFT_RESET;
         ground_margin_ff <= GROUND_MARGIN_RESET;
         sky_margin_ff    <= SKY_MARGIN_RESET;
         sweep_cnt_ff     <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         cell_shift_ff    <= cell_shift_in;
         ground_margin_ff <= ground_margin_in;
         sky_margin_ff    <= sky_margin_in;
         sweep_cnt_ff     <= sweep_cnt_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      kept_ff     <= kept_in;
      sum_x_ff    <= sum_x_in;
      sum_y_ff    <= sum_y_in;
      z_ff        <= z_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      in_grid_ff  <= in_grid_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign status.req_is_clear = (req_payload.operation == OP_CLEAR);
   assign status.sweep_last   = (sweep_cnt_ff == ADDR_W'(DEPTH - 1));
   assign status.update_hold  = emit && rsp_valid_ff && rsp_stall;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule

// ----- rtl/core/grid_min_height_ground_filter.sv -----
// point item: capture, bin, memory read and update steps around the two-port cell
//   ram; result registered at update, which waits while a kept point is stalled
// clear item: GRID_CELLS*GRID_CELLS ram entries cleared, one written per cycle
// reset: synchronous, config to defaults, then a clearing pass over all
//   cells (65536 at default) with req_stall high; csr writes still taken
// top level, depends on gmhgf_pkg, gmhgf_ctrl, gmhgf_datapath and the assert header
`timescale 1ns / 1ps
`include "grid_min_height_ground_filter_assert.svh"

module grid_min_height_ground_filter
   import gmhgf_pkg::*;
#(
   parameter int GRID_CELLS = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_payload_type        req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_payload_type        rsp_payload,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   ctrl_cmd_type  ctrl_cmd;
   dp_status_type dp_status;

   gmhgf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (dp_status),
      .cmd       (ctrl_cmd)
   );

   gmhgf_datapath #(
      .GRID_CELLS (GRID_CELLS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .cmd         (ctrl_cmd),
      .status      (dp_status)
   );

   `GMHGF_ASSERT_IMPL(a_no_accept_in_sweep, clock, reset, ctrl_cmd.sweep, req_stall)
   `GMHGF_ASSERT_IMPL(a_result_from_update, clock, reset, $rose(rsp_valid), $past(ctrl_cmd.update))
   `GMHGF_ASSERT_NEXT(a_ready_after_update, clock, reset, ctrl_cmd.update, !req_stall)

endmodule

// ----- tb/sv/tb_grid_min_height_ground_filter.sv -----
// self-checking testbench for the grid minimum-height ground filter: directed and
// random items, kept points checked against a cell-minimum map kept here
// depends on gmhgf_pkg and grid_min_height_ground_filter
`timescale 1ns / 1ps

module tb_grid_min_height_ground_filter;
   import gmhgf_pkg::*;

   localparam int GRID = 256;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int HOT = 6;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_payload_type rsp_payload;
   logic csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // register copies and the lowest height seen per cell
   logic [3:0] cfg_shift = CELL_SHIFT_RESET;
   logic [14:0] cfg_ground = GROUND_MARGIN_RESET;
   logic [14:0] cfg_sky = SKY_MARGIN_RESET;
   logic signed [15:0] min_map [GRID*GRID];

   req_payload_type pending_items[$];
   rsp_payload_type kept_expect[$];

   bit req_fire = 1'b0;
   int req_gap = 0, req_calm = 0, stall_left = 0, rsp_calm = 0;
   int n_items = 0, n_filters = 0, n_clears = 0, n_kept = 0, n_errors = 0, n_settings = 1;

   grid_min_height_ground_filter #(.GRID_CELLS(GRID)) u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic int sat16(input int v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   function automatic int pick_idle(inout int calm);
      int r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 2) calm = $urandom_range(20, 60);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic void empty_map();
      foreach (min_map[i]) min_map[i] = CELL_EMPTY;
   endfunction

   function automatic bit cell_at(input int x, input int y, output int idx);
      int cx, cy;
      cx = (x >>> cfg_shift) + GRID / 2;
      cy = (y >>> cfg_shift) + GRID / 2;
      idx = cx * GRID + cy;
      return cx >= 0 && cx < GRID && cy >= 0 && cy < GRID;
   endfunction

   task automatic predict_kept_point(input req_payload_type it);
      int x, y, z, m, idx;
      rsp_payload_type r;
      case (it.operation)
         OP_CLEAR: begin
            empty_map();
            n_clears++;
         end
         OP_ACCUMULATE: begin
            x = int'($signed(it.pos_x)) + int'($signed(it.shift_x));
            y = int'($signed(it.pos_y)) + int'($signed(it.shift_y));
            z = sat16(int'($signed(it.pos_z)) + int'($signed(it.shift_z)));
            if (cell_at(x, y, idx)) begin
               if (z < int'(min_map[idx])) min_map[idx] = 16'(z);
            end
         end
         OP_FILTER: begin
            n_filters++;
            z = int'($signed(it.pos_z));
            if (cell_at(int'($signed(it.pos_x)), int'($signed(it.pos_y)), idx)) begin
               m = int'(min_map[idx]);
               if (m + int'(cfg_ground) < z && z < m + int'(cfg_sky)) begin
                  r.kept_x = it.pos_x;
                  r.kept_y = it.pos_y;
                  r.kept_z = it.pos_z;
                  kept_expect = {kept_expect, r};
               end
            end
         end
         default: ;
      endcase
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("MISMATCH at %0t: %s got %0d expected %0d", $time, what, got, want);
      n_errors++;
   endtask

   // item driver
   always @(negedge clock) begin : drive_req
      logic nv;
      req_payload_type np;
      nv = req_valid;
      np = req_payload;
      if (reset) begin
         nv = 1'b0;
      end else if (!req_valid || req_fire) begin
         nv = 1'b0;
         if (req_gap > 0) begin
            req_gap--;
         end else if (pending_items.size() != 0) begin
            np = pending_items.pop_front();
            nv = 1'b1;
            req_gap = pick_idle(req_calm);
         end
      end
      req_valid <= nv;
      req_payload <= np;
   end

   always @(negedge clock) begin : drive_stall
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         stall_left = pick_idle(rsp_calm);
      end
   end

   // monitor and checker
   always @(posedge clock) begin : watch
      rsp_payload_type want;
      req_fire = !reset && req_valid && !req_stall;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            n_kept++;
            if (kept_expect.size() == 0) begin
               report_mismatch("unexpected kept_x", int'(rsp_payload.kept_x), 0);
            end else begin
               want = kept_expect.pop_front();
               if (rsp_payload.kept_x !== want.kept_x)
                  report_mismatch("kept_x", int'(rsp_payload.kept_x), int'(want.kept_x));
               if (rsp_payload.kept_y !== want.kept_y)
                  report_mismatch("kept_y", int'(rsp_payload.kept_y), int'(want.kept_y));
               if (rsp_payload.kept_z !== want.kept_z)
                  report_mismatch("kept_z", int'(rsp_payload.kept_z), int'(want.kept_z));
            end
         end
         if (req_fire) begin
            n_items++;
            predict_kept_point(req_payload);
         end
      end
   end

   task automatic add_item(input logic [1:0] op, input int x, input int y, input int z,
                           input int sx, input int sy, input int sz);
      req_payload_type it;
      it.operation = op;
      it.pos_x = 16'(x);
      it.pos_y = 16'(y);
      it.pos_z = 16'(z);
      it.shift_x = 16'(sx);
      it.shift_y = 16'(sy);
      it.shift_z = 16'(sz);
      pending_items = {pending_items, it};
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [14:0] val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_CELL_SHIFT: cfg_shift = val[3:0];
         CSR_GROUND_MARGIN: cfg_ground = val;
         CSR_SKY_MARGIN: cfg_sky = val;
         default: ;
      endcase
   endtask

   task automatic set_config(input int shift, input int ground, input int sky);
      write_reg(CSR_CELL_SHIFT, {11'($urandom), 4'(shift)});
      write_reg(CSR_GROUND_MARGIN, 15'(ground));
      write_reg(CSR_SKY_MARGIN, 15'(sky));
      if (n_settings == 3) write_reg(CSR_UNUSED, 15'($urandom));
      @(negedge clock);
      csr_wr_en <= 1'b0;
      n_settings++;
   endtask

   // sender holds off until every kept point is back and the pipe is empty
   task automatic settle();
      while (pending_items.size() != 0 || req_valid || kept_expect.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   function automatic int spot_in_cell(input int c);
      int base;
      base = (c >>> cfg_shift) << cfg_shift;
      return sat16(base + int'($urandom_range(0, (1 << cfg_shift) - 1)));
   endfunction

   function automatic int random_part(input int t);
      int a;
      a = int'($signed(16'($urandom)));
      if (t - a >= -32768 && t - a <= 32767) return a;
      return t / 2;
   endfunction

   task automatic fill_phase(input int count, input bit with_clear);
      req_payload_type it;
      int hx[HOT], hy[HOT], hz[HOT];
      bit seen[HOT];
      int i, made, pick, h, lo, hi, tx, ty, tz, g, k, p;
      lo = sat16(-(128 << cfg_shift));
      hi = sat16((128 << cfg_shift) - 1);
      g = int'(cfg_ground);
      k = int'(cfg_sky);
      for (i = 0; i < HOT; i++) begin
         hx[i] = lo + int'($urandom_range(0, hi - lo));
         hy[i] = lo + int'($urandom_range(0, hi - lo));
         hz[i] = int'($urandom_range(0, 60000)) - 30000;
         seen[i] = 1'b0;
      end
      if (with_clear) add_item(OP_CLEAR, 0, 0, 0, 0, 0, 0);
      made = 0;
      while (made < count) begin
         h = $urandom_range(0, HOT - 1);
         pick = $urandom_range(0, 99);
         it = '0;
         if (pick < 35) begin
            it.operation = OP_ACCUMULATE;
            tx = spot_in_cell(hx[h]);
            ty = spot_in_cell(hy[h]);
            tz = seen[h] ? sat16(hz[h] + int'($urandom_range(0, 400))) : hz[h];
            seen[h] = 1'b1;
            p = random_part(tx);
            it.pos_x = 16'(p);
            it.shift_x = 16'(tx - p);
            p = random_part(ty);
            it.pos_y = 16'(p);
            it.shift_y = 16'(ty - p);
            p = random_part(tz);
            it.pos_z = 16'(p);
            it.shift_z = 16'(tz - p);
            if ($urandom_range(0, 19) == 0) begin
               it.pos_z = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
               it.shift_z = it.pos_z;
            end
            made++;
         end else if (pick < 80) begin
            it.operation = OP_FILTER;
            it.pos_x = 16'(spot_in_cell(hx[h]));
            it.pos_y = 16'(spot_in_cell(hy[h]));
            case ($urandom_range(0, 7))
               0: tz = hz[h] + g;
               1: tz = hz[h] + g + 1;
               2: tz = hz[h] + k - 1;
               3: tz = hz[h] + k;
               4: tz = hz[h] + g + 1 + int'($urandom_range(0, (k > g + 2) ? k - g - 2 : 0));
               5: tz = int'($signed(16'($urandom)));
               6: tz = hz[h] + g - 1;
               default: tz = hz[h] + k + 1;
            endcase
            it.pos_z = 16'(sat16(tz));
            it.shift_x = 16'($urandom);
            it.shift_y = 16'($urandom);
            it.shift_z = 16'($urandom);
            made++;
         end else begin
            case ($urandom_range(0, 2))
               0: it.operation = OP_ACCUMULATE;
               1: it.operation = OP_FILTER;
               default: it.operation = OP_UNUSED;
            endcase
            it.pos_x = 16'($urandom);
            it.pos_y = 16'($urandom);
            it.pos_z = 16'($urandom);
            it.shift_x = 16'($urandom);
            it.shift_y = 16'($urandom);
            it.shift_z = 16'($urandom);
            if (it.operation != OP_UNUSED) made++;
         end
         pending_items = {pending_items, it};
      end
   endtask

   initial begin
      empty_map();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: 0.5 m cells, margins 26 and 768
      add_item(OP_FILTER, 0, 0, 100, 0, 0, 0);
      add_item(OP_ACCUMULATE, 0, 0, 0, 0, 0, 0);
      add_item(OP_FILTER, 5, 5, 27, 0, 0, 0);
      add_item(OP_FILTER, 127, 127, 26, 0, 0, 0);
      add_item(OP_FILTER, 0, 127, 767, 0, 0, 0);
      add_item(OP_FILTER, 0, 0, 768, 0, 0, 0);
      add_item(OP_ACCUMULATE, -1, -1, -500, 0, 0, 0);
      add_item(OP_FILTER, -128, -128, -400, 0, 0, 0);
      add_item(OP_FILTER, -129, -1, -400, 0, 0, 0);
      add_item(OP_ACCUMULATE, 1000, 1000, 32767, 0, 0, 32767);
      add_item(OP_FILTER, 1000, 1000, -32768, 0, 0, 0);
      add_item(OP_ACCUMULATE, -1000, 1000, -32768, 0, 0, -32768);
      add_item(OP_FILTER, -1000, 1000, -32741, 0, 0, 0);
      add_item(OP_ACCUMULATE, 32767, 0, -9000, 32767, 0, 0);
      add_item(OP_FILTER, 32767, 0, 0, 0, 0, 0);
      add_item(OP_ACCUMULATE, 32767, 0, -9000, -32767, 0, 0);
      add_item(OP_FILTER, 0, 0, -8500, 0, 0, 0);
      add_item(OP_ACCUMULATE, -16384, 16383, 5, 0, 0, 0);
      add_item(OP_FILTER, -16384, 16383, 40, 0, 0, 0);
      add_item(OP_FILTER, 16384, 0, 100, 0, 0, 0);
      add_item(OP_UNUSED, -32768, 32767, -32768, 32767, -32768, 32767);
      add_item(OP_ACCUMULATE, -32768, -32768, -32768, -32768, -32768, -32768);
      add_item(OP_CLEAR, 0, 0, 0, 0, 0, 0);
      add_item(OP_FILTER, 0, 0, -8500, 0, 0, 0);
      settle();

      set_config(0, 0, 32767);
      fill_phase(140, 1'b1);
      settle();
      set_config(12, 32767, 32767);
      fill_phase(140, 1'b0);
      settle();
      set_config(15, 0, 0);
      fill_phase(140, 1'b1);
      settle();
      set_config(7, 26, 768);
      fill_phase(140, 1'b0);
      settle();
      set_config(4, 100, 3000);
      fill_phase(140, 1'b1);
      settle();
      set_config($urandom_range(0, 15), $urandom_range(0, 200), $urandom_range(0, 32767));
      fill_phase(140, 1'b0);
      settle();
      set_config(9, 5, 32767);
      fill_phase(140, 1'b1);
      settle();

      $display("covered %0d items: %0d filters, %0d clears, %0d register settings",
               n_items, n_filters, n_clears, n_settings);
      $display("checked %0d kept points, %0d mismatches", n_kept, n_errors);
      if (n_errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #50_000_000;
      $display("timeout with %0d items pending, %0d kept points outstanding",
               pending_items.size(), kept_expect.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/gmhgf_pkg.sv
rtl/core/gmhgf_ram.sv
rtl/core/gmhgf_ctrl.sv
rtl/core/gmhgf_datapath.sv
rtl/core/grid_min_height_ground_filter.sv
tb/sv/tb_grid_min_height_ground_filter.sv
